// ----- hw/rtl/tws_pkg.sv -----
// Shared types and constants of the textured wall column stepper.
`timescale 1ns / 1ps

package tws_pkg;

    // Field widths
    localparam int COL_W   = 11;
    localparam int ROW_W   = 11;
    localparam int HGT_W   = 12;
    localparam int TEX_W   = 11;
    localparam int TXC_W   = 10;
    localparam int DIST_W  = 20;
    localparam int FRAC_W  = 16;
    localparam int COLOR_W = 24;
    localparam int LINE_W  = 16;
    localparam int STEP_W  = 32;
    localparam int OFF_W   = 15;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURE_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING_COLOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COLOR    = 3'd4;

    localparam logic [HGT_W-1:0]   RST_SCREEN_HEIGHT = 12'd480;
    localparam logic [TEX_W-1:0]   RST_TEXTURE_SIZE  = 11'd64;
    localparam logic [COLOR_W-1:0] RST_CEILING_COLOR = 24'd2201000;
    localparam logic [COLOR_W-1:0] RST_FLOOR_COLOR   = 24'd225300;

    // Parameter defaults
    localparam int DEF_MAX_SCREEN_HEIGHT = 2048;
    localparam int DEF_MAX_TEX_SIZE      = 1024;

    // Region codes
    localparam logic [1:0] REGION_CEILING = 2'd0;
    localparam logic [1:0] REGION_WALL    = 2'd1;
    localparam logic [1:0] REGION_FLOOR   = 2'd2;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Shared divider: (h << 10) / dist and (th << 16) / line_h
    localparam int DIV_NUM_W = 27;
    localparam int DIV_DEN_W = 20;

    // Classified input word
    typedef struct packed {
        logic              is_pixel;
        logic [COL_W-1:0]  column;
        logic [DIST_W-1:0] perp_dist;
        logic [FRAC_W-1:0] wall_frac;
        logic              hit_side;
        logic              flip;
    } t_item;

    // Effective (clamped) configuration
    typedef struct packed {
        logic [HGT_W-1:0]   height;
        logic [TEX_W-1:0]   tex_w;
        logic [TEX_W-1:0]   tex_h;
        logic [COLOR_W-1:0] ceiling;
        logic [COLOR_W-1:0] floor_c;
    } t_cfg;

endpackage

// ----- hw/rtl/tws_front.sv -----
// Front end: accepts input words, classifies them and queues them for the back end.
`timescale 1ns / 1ps

module tws_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_req_type,
    input  logic [tws_pkg::COL_W-1:0]  i_column,
    input  logic [tws_pkg::DIST_W-1:0] i_perp_dist,
    input  logic [tws_pkg::FRAC_W-1:0] i_wall_frac,
    input  logic                       i_hit_side,
    input  logic                       i_dir_x_positive,
    input  logic                       i_dir_y_negative,
    output tws_pkg::t_item             o_head,
    output logic                       o_head_valid,
    input  logic                       i_pop
);

    localparam int DEPTH = tws_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tws_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    tws_pkg::t_item   item;

    assign o_stall      = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];
    assign push         = i_valid && !o_stall;

    // Flip the texture column on faces seen from the far side.
    always_comb begin
        item.is_pixel  = i_req_type;
        item.column    = i_column;
        item.perp_dist = i_perp_dist;
        item.wall_frac = i_wall_frac;
        item.hit_side  = i_hit_side;
        item.flip      = i_hit_side ? i_dir_y_negative : i_dir_x_positive;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_pop_not_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("front: pop from empty queue");

    a_push_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("front: queue count lost a push");

    a_empty_ptrs : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("front: pointers disagree on empty queue");

endmodule

// ----- hw/rtl/tws_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module tws_div #(
    parameter int NUM_W = tws_pkg::DIV_NUM_W,
    parameter int DEN_W = tws_pkg::DIV_DEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;
    logic [DEN_W:0]   rem_sh, diff;
    logic             ge;

    // Divide by zero yields all ones.
    assign rem_sh = {r_rem, r_quot[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = (rem_sh >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quot = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_quot <= '0;
            r_rem  <= '0;
            r_den  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quot <= {r_quot[NUM_W-2:0], ge};
                r_rem  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/tws_back.sv -----
// Back end: column setup through the shared divider, then one pixel row per word.
`timescale 1ns / 1ps

module tws_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tws_pkg::t_cfg               i_cfg,
    input  tws_pkg::t_item              i_head,
    input  logic                        i_head_valid,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [tws_pkg::COL_W-1:0]   o_out_column,
    output logic [tws_pkg::ROW_W-1:0]   o_out_row,
    output logic [1:0]                  o_region,
    output logic [tws_pkg::TXC_W-1:0]   o_tex_x,
    output logic [tws_pkg::TXC_W-1:0]   o_tex_y,
    output logic                        o_shade,
    output logic [tws_pkg::COLOR_W-1:0] o_fill_color,
    output logic                        o_last_row
);

    localparam int HGT_W  = tws_pkg::HGT_W;
    localparam int TEX_W  = tws_pkg::TEX_W;
    localparam int LINE_W = tws_pkg::LINE_W;
    localparam int STEP_W = tws_pkg::STEP_W;
    localparam int OFF_W  = tws_pkg::OFF_W;
    localparam int NUM_W  = tws_pkg::DIV_NUM_W;
    localparam int DEN_W  = tws_pkg::DIV_DEN_W;
    localparam int PROD_W = OFF_W + STEP_W;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV_H, ST_DIV_T, ST_POS} t_state;

    t_state r_state;

    logic [tws_pkg::COL_W-1:0] r_cur_column;
    logic [tws_pkg::TXC_W-1:0] r_tex_column;
    logic                      r_y_face;
    logic [HGT_W-1:0]          r_wall_top, r_wall_bottom;
    logic [STEP_W-1:0]         r_tex_step, r_tex_pos;
    logic [tws_pkg::ROW_W-1:0] r_row_count;
    logic                      r_live;
    logic                      r_dist_zero;
    logic [LINE_W-1:0]         r_line_h;
    logic [OFF_W-1:0]          r_off;
    logic                      r_div_start;
    logic [NUM_W-1:0]          r_div_num;
    logic [DEN_W-1:0]          r_div_den;

    logic             div_done;
    logic [NUM_W-1:0] div_quot;

    // pixel path
    logic [HGT_W-1:0]   half_h, row_ext;
    logic               in_wall, is_last;
    logic [TEX_W-1:0]   th_m1, ty;
    logic [LINE_W-1:0]  ty_raw;
    logic               emit;
    // load path
    logic [NUM_W-1:0]  tc_prod;
    logic [TEX_W-1:0]  tc_raw, tc_sel;
    // line height path
    logic [LINE_W-1:0] n_line_h;
    logic [OFF_W-1:0]  half_l, half_h15;
    logic [HGT_W-1:0]  n_wall_top, n_wall_bottom, h_m1;
    logic [LINE_W-1:0] bot_sum;
    logic [OFF_W-1:0]  n_off;
    logic [PROD_W-1:0] n_pos_prod;

    tws_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_pop = (r_state == ST_IDLE) && i_head_valid
                 && (!i_head.is_pixel || !o_valid || !i_stall);
    assign emit  = o_pop && i_head.is_pixel && r_live;

    // Row classification and texel row for the current pixel
    always_comb begin
        half_h  = i_cfg.height >> 1;
        h_m1    = i_cfg.height - 12'd1;
        row_ext = {1'b0, r_row_count};
        in_wall = (row_ext >= r_wall_top) && (row_ext < r_wall_bottom);
        is_last = (row_ext >= h_m1);
        th_m1   = i_cfg.tex_h - 11'd1;
        ty_raw  = r_tex_pos[STEP_W-1:16];
        ty      = (ty_raw > LINE_W'(th_m1)) ? th_m1 : ty_raw[TEX_W-1:0];
    end

    // Texture column of a load word
    always_comb begin
        tc_prod = NUM_W'(i_head.wall_frac) * NUM_W'(i_cfg.tex_w);
        tc_raw  = tc_prod[NUM_W-1:16];
        tc_sel  = i_head.flip ? (i_cfg.tex_w - tc_raw - 11'd1) : tc_raw;
    end

    // Line height, wall span and texture offset from the first quotient
    always_comb begin
        n_line_h = (r_dist_zero || (div_quot[NUM_W-1:LINE_W] != '0))
                 ? {LINE_W{1'b1}} : div_quot[LINE_W-1:0];
        half_l   = n_line_h[LINE_W-1:1];
        half_h15 = OFF_W'(half_h);
        if (half_l >= half_h15) begin
            n_wall_top = '0;
            n_off      = half_l - half_h15;
        end else begin
            n_wall_top = half_h - HGT_W'(half_l);
            n_off      = '0;
        end
        bot_sum       = LINE_W'(half_l) + LINE_W'(half_h);
        n_wall_bottom = (bot_sum > LINE_W'(h_m1)) ? h_m1 : bot_sum[HGT_W-1:0];
        n_pos_prod    = PROD_W'(r_off) * PROD_W'(r_tex_step);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_live        <= 1'b0;
            r_cur_column  <= '0;
            r_tex_column  <= '0;
            r_y_face      <= 1'b0;
            r_wall_top    <= '0;
            r_wall_bottom <= '0;
            r_tex_step    <= '0;
            r_tex_pos     <= '0;
            r_row_count   <= '0;
            r_dist_zero   <= 1'b0;
            r_line_h      <= '0;
            r_off         <= '0;
            r_div_start   <= 1'b0;
            r_div_num     <= '0;
            r_div_den     <= '0;
            o_valid       <= 1'b0;
            o_out_column  <= '0;
            o_out_row     <= '0;
            o_region      <= tws_pkg::REGION_CEILING;
            o_tex_x       <= '0;
            o_tex_y       <= '0;
            o_shade       <= 1'b0;
            o_fill_color  <= '0;
            o_last_row    <= 1'b0;
        end else begin
            r_div_start <= 1'b0;

            // output register
            if (emit) begin
                o_valid      <= 1'b1;
                o_out_column <= r_cur_column;
                o_out_row    <= r_row_count;
                o_last_row   <= is_last;
                if (in_wall) begin
                    o_region     <= tws_pkg::REGION_WALL;
                    o_tex_x      <= r_tex_column;
                    o_tex_y      <= ty[tws_pkg::TXC_W-1:0];
                    o_shade      <= r_y_face;
                    o_fill_color <= '0;
                end else begin
                    o_region     <= (row_ext < half_h) ? tws_pkg::REGION_CEILING
                                                       : tws_pkg::REGION_FLOOR;
                    o_tex_x      <= '0;
                    o_tex_y      <= '0;
                    o_shade      <= 1'b0;
                    o_fill_color <= (row_ext < half_h) ? i_cfg.ceiling : i_cfg.floor_c;
                end
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (emit) begin
                        if (in_wall) begin
                            r_tex_pos <= r_tex_pos + r_tex_step;
                        end
                        if (is_last) begin
                            r_live      <= 1'b0;
                            r_row_count <= '0;
                        end else begin
                            r_row_count <= r_row_count + 1'b1;
                        end
                    end else if (o_pop && !i_head.is_pixel) begin
                        r_cur_column <= i_head.column;
                        r_tex_column <= tc_sel[tws_pkg::TXC_W-1:0];
                        r_y_face     <= i_head.hit_side;
                        r_dist_zero  <= (i_head.perp_dist == '0);
                        r_div_start  <= 1'b1;
                        r_div_num    <= NUM_W'({i_cfg.height, 10'd0});
                        r_div_den    <= i_head.perp_dist;
                        r_state      <= ST_DIV_H;
                    end
                end
                ST_DIV_H: begin
                    if (div_done) begin
                        r_line_h      <= n_line_h;
                        r_wall_top    <= n_wall_top;
                        r_wall_bottom <= n_wall_bottom;
                        r_off         <= n_off;
                        r_div_start   <= 1'b1;
                        r_div_num     <= NUM_W'({i_cfg.tex_h, 16'd0});
                        r_div_den     <= DEN_W'(n_line_h);
                        r_state       <= ST_DIV_T;
                    end
                end
                ST_DIV_T: begin
                    if (div_done) begin
                        r_tex_step <= (r_line_h == '0) ? '0 : STEP_W'(div_quot);
                        r_state    <= ST_POS;
                    end
                end
                ST_POS: begin
                    r_tex_pos   <= n_pos_prod[STEP_W-1:0];
                    r_row_count <= '0;
                    r_live      <= 1'b1;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_done_in_div : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV_H || r_state == ST_DIV_T))
        else $error("back: divider finished outside column setup");

    a_load_starts : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && !i_head.is_pixel) |=> (r_state == ST_DIV_H && r_div_start))
        else $error("back: load word did not start the divider");

    a_wall_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wall_top <= r_wall_bottom)
        else $error("back: wall top below wall bottom");

    a_last_ends : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && is_last) |=> !r_live)
        else $error("back: column still live after its last row");

endmodule

// ----- hw/rtl/textured_wall_column_stepper_core.sv -----
// Top level of the textured wall column stepper: config registers, front and back.
`timescale 1ns / 1ps

// Usage:
//  Input channel (i_valid / o_stall) takes one word per accepted edge. A load
//  word (req_type 0) sets up a screen column; each pixel word (req_type 1)
//  gives one row of that column, top to bottom, on the output channel
//  (o_valid / i_stall). Loads give no output; pixel words with no live column
//  are dropped.
//  Throughput: pixel words stream at one per cycle while no load is being set
//  up and the output is not stalled. A load holds the back end for two passes
//  through the one-bit-per-cycle divider (line height, then texture step),
//  then a step that sets the texture start position, before it resumes.
//  The output word is registered in the back end as the pixel word is popped.
//  A 4-word queue decouples the input from the back end, so input words keep
//  being taken while a load is being set up or the output is stalled; o_stall
//  rises only when that queue is full.
//  When i_stall is high the output word holds; pixel words wait for it.
//  Reset (synchronous, active low) empties the queue, drops any live column
//  and returns the config registers to their defaults. Config writes
//  (i_cfg_we, i_cfg_index, i_cfg_data) are meant for idle periods only.
module textured_wall_column_stepper_core #(
    parameter int MAX_SCREEN_HEIGHT = tws_pkg::DEF_MAX_SCREEN_HEIGHT,
    parameter int MAX_TEX_SIZE      = tws_pkg::DEF_MAX_TEX_SIZE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config port
    input  logic                          i_cfg_we,
    input  logic [tws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tws_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic [tws_pkg::COL_W-1:0]     i_column,
    input  logic [tws_pkg::DIST_W-1:0]    i_perp_dist,
    input  logic [tws_pkg::FRAC_W-1:0]    i_wall_frac,
    input  logic                          i_hit_side,
    input  logic                          i_dir_x_positive,
    input  logic                          i_dir_y_negative,
    // output channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [tws_pkg::COL_W-1:0]     o_out_column,
    output logic [tws_pkg::ROW_W-1:0]     o_out_row,
    output logic [1:0]                    o_region,
    output logic [tws_pkg::TXC_W-1:0]     o_tex_x,
    output logic [tws_pkg::TXC_W-1:0]     o_tex_y,
    output logic                          o_shade,
    output logic [tws_pkg::COLOR_W-1:0]   o_fill_color,
    output logic                          o_last_row
);

    localparam int HGT_W = tws_pkg::HGT_W;
    localparam int TEX_W = tws_pkg::TEX_W;
    localparam int CMP_W = 13;   // holds any limit up to 4096

    // Raw config registers
    logic [HGT_W-1:0]            r_screen_height;
    logic [TEX_W-1:0]            r_texture_width, r_texture_height;
    logic [tws_pkg::COLOR_W-1:0] r_ceiling_color, r_floor_color;

    tws_pkg::t_cfg  cfg;
    tws_pkg::t_item head;
    logic           head_valid, pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height  <= tws_pkg::RST_SCREEN_HEIGHT;
            r_texture_width  <= tws_pkg::RST_TEXTURE_SIZE;
            r_texture_height <= tws_pkg::RST_TEXTURE_SIZE;
            r_ceiling_color  <= tws_pkg::RST_CEILING_COLOR;
            r_floor_color    <= tws_pkg::RST_FLOOR_COLOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tws_pkg::CFG_SCREEN_HEIGHT:  r_screen_height  <= i_cfg_data[HGT_W-1:0];
                tws_pkg::CFG_TEXTURE_WIDTH:  r_texture_width  <= i_cfg_data[TEX_W-1:0];
                tws_pkg::CFG_TEXTURE_HEIGHT: r_texture_height <= i_cfg_data[TEX_W-1:0];
                tws_pkg::CFG_CEILING_COLOR:  r_ceiling_color  <= i_cfg_data;
                tws_pkg::CFG_FLOOR_COLOR:    r_floor_color    <= i_cfg_data;
                default: ;  // unknown index: ignored
            endcase
        end
    end

    // Clamp registers into their usable ranges
    always_comb begin
        if (r_screen_height < 12'd2) begin
            cfg.height = 12'd2;
        end else if (CMP_W'(r_screen_height) > CMP_W'(MAX_SCREEN_HEIGHT)) begin
            cfg.height = HGT_W'(MAX_SCREEN_HEIGHT);
        end else begin
            cfg.height = r_screen_height;
        end

        if (r_texture_width == '0) begin
            cfg.tex_w = 11'd1;
        end else if (CMP_W'(r_texture_width) > CMP_W'(MAX_TEX_SIZE)) begin
            cfg.tex_w = TEX_W'(MAX_TEX_SIZE);
        end else begin
            cfg.tex_w = r_texture_width;
        end

        if (r_texture_height == '0) begin
            cfg.tex_h = 11'd1;
        end else if (CMP_W'(r_texture_height) > CMP_W'(MAX_TEX_SIZE)) begin
            cfg.tex_h = TEX_W'(MAX_TEX_SIZE);
        end else begin
            cfg.tex_h = r_texture_height;
        end

        cfg.ceiling = r_ceiling_color;
        cfg.floor_c = r_floor_color;
    end

    tws_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_column         (i_column),
        .i_perp_dist      (i_perp_dist),
        .i_wall_frac      (i_wall_frac),
        .i_hit_side       (i_hit_side),
        .i_dir_x_positive (i_dir_x_positive),
        .i_dir_y_negative (i_dir_y_negative),
        .o_head           (head),
        .o_head_valid     (head_valid),
        .i_pop            (pop)
    );

    tws_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_column (o_out_column),
        .o_out_row    (o_out_row),
        .o_region     (o_region),
        .o_tex_x      (o_tex_x),
        .o_tex_y      (o_tex_y),
        .o_shade      (o_shade),
        .o_fill_color (o_fill_color),
        .o_last_row   (o_last_row)
    );

endmodule

// ----- verif/tws_column_checker.sv -----
// Checker for the textured wall column stepper: tracks config, predicts pixel words, compares.
`timescale 1ns / 1ps

module tws_column_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tws_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tws_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_req_type,
    input  logic [tws_pkg::COL_W-1:0]     i_column,
    input  logic [tws_pkg::DIST_W-1:0]    i_perp_dist,
    input  logic [tws_pkg::FRAC_W-1:0]    i_wall_frac,
    input  logic                          i_hit_side,
    input  logic                          i_dir_x_positive,
    input  logic                          i_dir_y_negative,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [tws_pkg::COL_W-1:0]     i_out_column,
    input  logic [tws_pkg::ROW_W-1:0]     i_out_row,
    input  logic [1:0]                    i_region,
    input  logic [tws_pkg::TXC_W-1:0]     i_tex_x,
    input  logic [tws_pkg::TXC_W-1:0]     i_tex_y,
    input  logic                          i_shade,
    input  logic [tws_pkg::COLOR_W-1:0]   i_fill_color,
    input  logic                          i_last_row,
    output int                            o_pending,
    output int                            o_fail_count
);
    import tws_pkg::*;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [1:0]         region;
        logic [TXC_W-1:0]   tex_x;
        logic [TXC_W-1:0]   tex_y;
        logic               shade;
        logic [COLOR_W-1:0] fill;
        logic               last;
    } pixel_t;

    // Register copies
    bit [HGT_W-1:0]   rows_cfg;
    bit [TEX_W-1:0]   texw_cfg;
    bit [TEX_W-1:0]   texh_cfg;
    bit [COLOR_W-1:0] ceil_rgb;
    bit [COLOR_W-1:0] floor_rgb;

    // Column state
    bit [COL_W-1:0] cur_col;
    bit [TXC_W-1:0] tex_col;
    bit             y_face;
    bit [31:0]      wall_top;
    bit [31:0]      wall_bot;
    bit [31:0]      tex_step;
    bit [31:0]      tex_pos;
    bit [ROW_W-1:0] row_idx;
    bit             live;

    pixel_t pending_rows[$];

    function automatic bit [31:0] clamp_to(input bit [31:0] v, input bit [31:0] lo,
                                           input bit [31:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic setup_column(input bit [COL_W-1:0] col, input bit [DIST_W-1:0] dist_in,
                                input bit [FRAC_W-1:0] frac, input bit side,
                                input bit dxp, input bit dyn);
        bit [31:0] rows, tw, th, half_rows, span, half_span, quo, tc, offset;
        bit [63:0] prod;
        rows = clamp_to(32'(rows_cfg), 2, DEF_MAX_SCREEN_HEIGHT);
        tw   = clamp_to(32'(texw_cfg), 1, DEF_MAX_TEX_SIZE);
        th   = clamp_to(32'(texh_cfg), 1, DEF_MAX_TEX_SIZE);
        half_rows = rows >> 1;
        if (dist_in == '0) begin
            span = 32'd65535;
        end else begin
            quo  = (rows << 10) / {12'b0, dist_in};
            span = (quo > 32'd65535) ? 32'd65535 : quo;
        end
        half_span = span >> 1;
        wall_top = (half_span >= half_rows) ? 32'd0 : half_rows - half_span;
        wall_bot = half_span + half_rows;
        if (wall_bot > rows - 1) wall_bot = rows - 1;

        prod = {48'b0, frac} * {32'b0, tw};
        tc = prod[47:16];
        if ((!side && dxp) || (side && dyn)) tc = tw - tc - 1;
        tex_col = tc[TXC_W-1:0];

        if (span == 0) begin
            tex_step = '0;
        end else begin
            prod = ({32'b0, th} << 16) / {32'b0, span};
            tex_step = prod[31:0];
        end
        offset = wall_top + half_span - half_rows;
        prod = {32'b0, offset} * {32'b0, tex_step};
        tex_pos = prod[31:0];

        cur_col = col;
        y_face  = side;
        row_idx = '0;
        live    = 1'b1;
    endtask

    task automatic render_row(output bit made, output pixel_t px);
        bit [31:0] rows, th, row, ty;
        made = 1'b0;
        px   = '0;
        if (live) begin
            rows = clamp_to(32'(rows_cfg), 2, DEF_MAX_SCREEN_HEIGHT);
            row  = {21'b0, row_idx};
            px.column = cur_col;
            px.row    = row_idx;
            if (row >= wall_top && row < wall_bot) begin
                th = clamp_to(32'(texh_cfg), 1, DEF_MAX_TEX_SIZE);
                ty = tex_pos >> 16;
                if (ty > th - 1) ty = th - 1;
                tex_pos  = tex_pos + tex_step;
                px.region = REGION_WALL;
                px.tex_x  = tex_col;
                px.tex_y  = ty[TXC_W-1:0];
                px.shade  = y_face;
            end else if (row < (rows >> 1)) begin
                px.region = REGION_CEILING;
                px.fill   = ceil_rgb;
            end else begin
                px.region = REGION_FLOOR;
                px.fill   = floor_rgb;
            end
            px.last = (row >= rows - 1);
            if (px.last) begin
                live    = 1'b0;
                row_idx = '0;
            end else begin
                row_idx = row_idx + 11'd1;
            end
            made = 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : track
        pixel_t px;
        pixel_t want;
        bit     made;
        if (!i_rst_n) begin
            rows_cfg  = RST_SCREEN_HEIGHT;
            texw_cfg  = RST_TEXTURE_SIZE;
            texh_cfg  = RST_TEXTURE_SIZE;
            ceil_rgb  = RST_CEILING_COLOR;
            floor_rgb = RST_FLOOR_COLOR;
            cur_col   = '0;
            tex_col   = '0;
            y_face    = 1'b0;
            wall_top  = '0;
            wall_bot  = '0;
            tex_step  = '0;
            tex_pos   = '0;
            row_idx   = '0;
            live      = 1'b0;
            pending_rows.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCREEN_HEIGHT:  rows_cfg  = i_cfg_data[HGT_W-1:0];
                    CFG_TEXTURE_WIDTH:  texw_cfg  = i_cfg_data[TEX_W-1:0];
                    CFG_TEXTURE_HEIGHT: texh_cfg  = i_cfg_data[TEX_W-1:0];
                    CFG_CEILING_COLOR:  ceil_rgb  = i_cfg_data[COLOR_W-1:0];
                    CFG_FLOOR_COLOR:    floor_rgb = i_cfg_data[COLOR_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (!i_req_type) begin
                    setup_column(i_column, i_perp_dist, i_wall_frac, i_hit_side,
                                 i_dir_x_positive, i_dir_y_negative);
                end else begin
                    render_row(made, px);
                    if (made) pending_rows.push_back(px);
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_rows.size() == 0) begin
                    $error("unexpected pixel word: column %0d row %0d", i_out_column, i_out_row);
                    o_fail_count++;
                end else begin
                    want = pending_rows.pop_front();
                    check_field("out_column", 32'(want.column), 32'(i_out_column));
                    check_field("out_row",    32'(want.row),    32'(i_out_row));
                    check_field("region",     32'(want.region), 32'(i_region));
                    check_field("tex_x",      32'(want.tex_x),  32'(i_tex_x));
                    check_field("tex_y",      32'(want.tex_y),  32'(i_tex_y));
                    check_field("shade",      32'(want.shade),  32'(i_shade));
                    check_field("fill_color", 32'(want.fill),   32'(i_fill_color));
                    check_field("last_row",   32'(want.last),   32'(i_last_row));
                end
            end
        end
        o_pending = pending_rows.size();
    end

endmodule

// ----- verif/textured_wall_column_stepper_core_test.sv -----
// Testbench top for the textured wall column stepper: stimulus, output flow control, verdict.
`timescale 1ns / 1ps

module textured_wall_column_stepper_core_test;
    import tws_pkg::*;

    // Wait after the last expected row before touching config or ending:
    // a trailing load still runs through the divider and gives no word.
    localparam int SETTLE_CYCLES = 100;
    // Long output hold-off, in cycles, used once to back the block up.
    localparam int HOLD_CYCLES   = 600;

    logic clk = 1'b0;
    logic rst_n;

    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Input channel
    logic              in_valid;
    logic              in_stall;
    logic              req_type;
    logic [COL_W-1:0]  column;
    logic [DIST_W-1:0] perp_dist;
    logic [FRAC_W-1:0] wall_frac;
    logic              hit_side;
    logic              dir_x_pos;
    logic              dir_y_neg;

    // Output channel
    logic               out_valid;
    logic               out_stall;
    logic [COL_W-1:0]   out_column;
    logic [ROW_W-1:0]   out_row;
    logic [1:0]         region;
    logic [TXC_W-1:0]   tex_x;
    logic [TXC_W-1:0]   tex_y;
    logic               shade;
    logic [COLOR_W-1:0] fill_color;
    logic               last_row;

    int rows_pending;
    int fail_count;

    // Idle-stretch bookkeeping for the two sides, and the hold-off request.
    int tx_calm = 0;
    int rx_calm = 0;
    bit hold_req = 1'b0;

    always #5 clk = ~clk;

    textured_wall_column_stepper_core uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_req_type       (req_type),
        .i_column         (column),
        .i_perp_dist      (perp_dist),
        .i_wall_frac      (wall_frac),
        .i_hit_side       (hit_side),
        .i_dir_x_positive (dir_x_pos),
        .i_dir_y_negative (dir_y_neg),
        .o_valid          (out_valid),
        .i_stall          (out_stall),
        .o_out_column     (out_column),
        .o_out_row        (out_row),
        .o_region         (region),
        .o_tex_x          (tex_x),
        .o_tex_y          (tex_y),
        .o_shade          (shade),
        .o_fill_color     (fill_color),
        .o_last_row       (last_row)
    );

    tws_column_checker watch (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_req_type       (req_type),
        .i_column         (column),
        .i_perp_dist      (perp_dist),
        .i_wall_frac      (wall_frac),
        .i_hit_side       (hit_side),
        .i_dir_x_positive (dir_x_pos),
        .i_dir_y_negative (dir_y_neg),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_column     (out_column),
        .i_out_row        (out_row),
        .i_region         (region),
        .i_tex_x          (tex_x),
        .i_tex_y          (tex_y),
        .i_shade          (shade),
        .i_fill_color     (fill_color),
        .i_last_row       (last_row),
        .o_pending        (rows_pending),
        .o_fail_count     (fail_count)
    );

    // Per-word wait drawn at random; now and then a run of back-to-back words.
    task automatic draw_gap(inout int calm, output int gap);
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            calm = $urandom_range(8, 40);
            gap  = 0;
        end else begin
            gap = $urandom_range(0, 18);
        end
    endtask

    // Offer one word and hold it until taken. Entered and left at a falling
    // edge; with no gap valid stays high, so it is only ever written once
    // per step.
    task automatic send_word(input bit rt, input bit [COL_W-1:0] col,
                             input bit [DIST_W-1:0] distance, input bit [FRAC_W-1:0] frac,
                             input bit side, input bit dxp, input bit dyn);
        int gap;
        draw_gap(tx_calm, gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type  <= rt;
        column    <= col;
        perp_dist <= distance;
        wall_frac <= frac;
        hit_side  <= side;
        dir_x_pos <= dxp;
        dir_y_neg <= dyn;
        in_valid  <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Pixel words carry junk in the load fields; the block must ignore it.
    task automatic send_pixels(input int n);
        repeat (n) send_word(1'b1, COL_W'($urandom), DIST_W'($urandom), FRAC_W'($urandom),
                             1'($urandom), 1'($urandom), 1'($urandom));
    endtask

    // Distances spread so that line height saturates, hits zero, or lands
    // anywhere in between.
    task automatic send_random_load();
        bit [DIST_W-1:0] distance;
        bit [FRAC_W-1:0] frac;
        case ($urandom_range(0, 5))
            0:       distance = '0;
            1:       distance = DIST_W'($urandom_range(1, 64));
            2:       distance = DIST_W'($urandom_range(65, 4096));
            3:       distance = DIST_W'($urandom_range(4097, 20'hFFFFF));
            4:       distance = DIST_W'($urandom);
            default: distance = '1;
        endcase
        case ($urandom_range(0, 3))
            0:       frac = '0;
            1:       frac = '1;
            default: frac = FRAC_W'($urandom);
        endcase
        send_word(1'b0, COL_W'($urandom), distance, frac, 1'($urandom), 1'($urandom),
                  1'($urandom));
    endtask

    // Drop valid and wait for every predicted row to come back.
    task automatic wait_rows_done();
        in_valid <= 1'b0;
        do @(negedge clk); while (rows_pending != 0);
    endtask

    // Fully quiet: no rows owed and any trailing load setup finished.
    task automatic drain();
        wait_rows_done();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly whole columns (load plus one pixel word per row); some are cut
    // short by the next load, some overrun into dropped words, and a few
    // stray words of either kind are mixed in.
    task automatic run_columns(input int rows, input int target);
        int done;
        int npix;
        bit rt;
        done = 0;
        while (done < target) begin
            if ($urandom_range(0, 99) < 85) begin
                case ($urandom_range(0, 9))
                    0:       npix = $urandom_range(0, rows - 1);
                    1:       npix = rows + $urandom_range(1, 3);
                    default: npix = rows;
                endcase
                send_random_load();
                send_pixels(npix);
                done += 1 + ((npix < rows) ? npix : rows);
                if ($urandom_range(0, 24) == 0) wait_rows_done();
            end else begin
                rt = 1'($urandom);
                send_word(rt, COL_W'($urandom), DIST_W'($urandom), FRAC_W'($urandom),
                          1'($urandom), 1'($urandom), 1'($urandom));
                if (!rt) done++;
            end
        end
    endtask

    // Write every register (plus the unused indexes, which must do nothing),
    // then stream random columns and drain.
    task automatic run_phase(input logic [CFG_DAT_W-1:0] h, input logic [CFG_DAT_W-1:0] tw,
                             input logic [CFG_DAT_W-1:0] th, input logic [CFG_DAT_W-1:0] ceil_c,
                             input logic [CFG_DAT_W-1:0] floor_c, input int target);
        logic [CFG_IDX_W:0] idx;
        logic [HGT_W-1:0]   hv;
        int                 rows;
        cfg_write(CFG_SCREEN_HEIGHT, h);
        cfg_write(CFG_TEXTURE_WIDTH, tw);
        cfg_write(CFG_TEXTURE_HEIGHT, th);
        cfg_write(CFG_CEILING_COLOR, ceil_c);
        cfg_write(CFG_FLOOR_COLOR, floor_c);
        for (idx = {1'b0, CFG_FLOOR_COLOR} + 1'b1; !idx[CFG_IDX_W]; idx = idx + 1'b1)
            cfg_write(idx[CFG_IDX_W-1:0], CFG_DAT_W'($urandom));
        hv = h[HGT_W-1:0];
        rows = (hv < 2) ? 2 : ((hv > DEF_MAX_SCREEN_HEIGHT) ? DEF_MAX_SCREEN_HEIGHT : int'(hv));
        run_columns(rows, target);
        drain();
    endtask

    // Output side: stall for a drawn number of cycles, then take one word.
    // Honors a one-off long hold-off request from the stimulus.
    initial begin : receiver
        int gap;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                draw_gap(rx_calm, gap);
                if (gap > 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    initial begin : stimulus
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        req_type  = 1'b0;
        column    = '0;
        perp_dist = '0;
        wall_frac = '0;
        hit_side  = 1'b0;
        dir_x_pos = 1'b0;
        dir_y_neg = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Pixel word before any load: dropped.
        send_pixels(1);
        // One column at the reset register values.
        send_random_load();
        send_pixels(int'(RST_SCREEN_HEIGHT));
        drain();

        // Directed: short screen, narrow and tallest texture, extreme fill colors.
        cfg_write(CFG_SCREEN_HEIGHT, 24'd8);
        cfg_write(CFG_TEXTURE_WIDTH, 24'd16);
        cfg_write(CFG_TEXTURE_HEIGHT, 24'd1024);
        cfg_write(CFG_CEILING_COLOR, 24'h000000);
        cfg_write(CFG_FLOOR_COLOR, 24'hFFFFFF);
        // Zero distance: line height saturates, whole screen is wall but
        // the bottom row; x face with positive x direction flips the column.
        send_word(1'b0, 11'd0, 20'd0, 16'h0000, 1'b0, 1'b1, 1'b0);
        send_pixels(8);
        // Column already ended: dropped.
        send_pixels(1);
        // Farthest distance: zero line height, no wall; y face flipped.
        send_word(1'b0, 11'd2047, 20'hFFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b1);
        send_pixels(4);
        // Load mid column abandons it; distance 1.0, y face not flipped.
        send_word(1'b0, 11'd1234, 20'd1024, 16'h8000, 1'b1, 1'b1, 1'b0);
        send_pixels(8);
        drain();

        // Random phases, register extremes among them.
        run_phase(24'd16, 24'd64, 24'd64, CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), 200);
        run_phase(24'd2, 24'd1024, 24'd1, 24'hFFFFFF, 24'h000000, 100);
        run_phase(24'd0, 24'd0, 24'd0, CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), 80);
        run_phase(24'd40, 24'd2047, 24'd2047, CFG_DAT_W'($urandom), CFG_DAT_W'($urandom),
                  200);

        // Screen height lowered while a column is live: the next pixel word
        // is already past the new last row, so it ends the column.
        send_random_load();
        send_pixels(10);
        drain();
        cfg_write(CFG_SCREEN_HEIGHT, 24'd6);
        send_pixels(2);
        drain();

        run_phase(24'd24, CFG_DAT_W'($urandom_range(1, 1024)), CFG_DAT_W'($urandom_range(1, 1024)),
                  CFG_DAT_W'($urandom), CFG_DAT_W'($urandom), 200);

        // Tallest screen (out-of-range height clamps to the maximum), the top
        // rows of one column; the output side holds off early on so the block
        // backs up and stalls its input. The next load abandons the column.
        cfg_write(CFG_SCREEN_HEIGHT, 24'hFFF);
        cfg_write(CFG_TEXTURE_WIDTH, 24'd1024);
        cfg_write(CFG_TEXTURE_HEIGHT, 24'd1024);
        send_word(1'b0, COL_W'($urandom), 20'd1, FRAC_W'($urandom), 1'($urandom),
                  1'($urandom), 1'($urandom));
        hold_req = 1'b1;
        send_pixels(200);
        drain();

        run_phase(24'd100, CFG_DAT_W'($urandom_range(1, 1024)),
                  CFG_DAT_W'($urandom_range(1, 1024)), CFG_DAT_W'($urandom),
                  CFG_DAT_W'($urandom), 220);

        if (fail_count == 0) begin
            $display("textured_wall_column_stepper_core_test passed");
        end else begin
            $display("textured_wall_column_stepper_core_test failed");
        end
        $finish;
    end

    // Hang guard, well beyond the slowest legal run.
    initial begin : watchdog
        #8_000_000;
        $display("textured_wall_column_stepper_core_test failed");
        $finish;
    end

endmodule
